// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the microphone DC blocker.
// No dependencies; the macros expect signals clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every clock edge out of reset.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every clock edge out of reset.
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMP(label, ante, cons, msg)
`define ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// File: rtl/core/mdcb_pkg.sv
// Package for the microphone DC blocker: widths, register indexes and reset values.
// No dependencies.
package mdcb_pkg;

  // Sample width and the accumulator width that holds eight times a full-scale sample.
  localparam int SAMPLE_WIDTH = 16;
  localparam int ACC_W        = SAMPLE_WIDTH + 4;

  // Configuration port geometry.
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int SKIP_W    = 8;
  localparam int COUNT_W   = 24;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_COUNT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SAMPLES = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_RIGHT  = CFG_IDX_W'(2);

  // Register reset values.
  localparam logic [SKIP_W-1:0]  SKIP_RESET       = SKIP_W'(30);
  localparam logic [COUNT_W-1:0] MAX_RESET        = COUNT_W'(22050 * 10);
  localparam logic               KEEP_RIGHT_RESET = 1'b1;

  // Bounds of the accumulator: eight times the sample range.
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(8 * (2 ** (SAMPLE_WIDTH - 1)));
  localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_MAX;

endpackage

// File: rtl/core/mic_dc_blocking_filter.sv
// A result is presented in the cycle after its frame is accepted. Throughput: one frame
// per cycle unless the output stalls; the accumulator update is a combinational
// multiply-by-seven, truncating shift and add between the port and the result register.
// Reset: synchronous, active low; clears the filter state and loads the register defaults.
// Top level of the microphone DC blocker; uses mdcb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mic_dc_blocking_filter
  import mdcb_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_W-1:0]               cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_left_sample,
  input  logic signed [SAMPLE_WIDTH-1:0] in_right_sample,
  input  logic                           in_stop_request,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_filtered_sample,
  output logic                           out_last_sample
);

  localparam int PROD_W = ACC_W + 3;

  // Configuration registers.
  logic [SKIP_W-1:0]  skip_count_r;
  logic [COUNT_W-1:0] max_samples_r;
  logic               keep_right_r;

  // Filter state.
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [SKIP_W-1:0]       warm_cnt_r;
  logic                    seeded_r;
  logic [COUNT_W-1:0]      out_cnt_r, out_cnt_nxt;
  logic                    finished_r;

  // Result register.
  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r;
  logic                           out_last_r;

  // Datapath.
  logic signed [SAMPLE_WIDTH-1:0] x;
  logic signed [ACC_W-1:0]        x_ext, x8, acc_base, quot_tz, y_full;
  logic signed [PROD_W-1:0]       base_ext, prod7, quot;
  logic                           round_up;
  logic                           accept, active, warming, produce, last_nxt;

  // A new beat is taken whenever the result register is free or being drained.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign active   = accept && !finished_r;
  assign warming  = !seeded_r && (warm_cnt_r < skip_count_r);
  assign produce  = active && !warming;

  // Channel select and scaling by eight.
  assign x        = keep_right_r ? in_right_sample : in_left_sample;
  assign x_ext    = ACC_W'(x);
  assign x8       = x_ext <<< 3;
  assign acc_base = seeded_r ? acc_r : x8;

  // acc*7/8 with truncation toward zero, then add the new sample.
  assign base_ext = PROD_W'(acc_base);
  assign prod7    = (base_ext <<< 3) - base_ext;
  assign quot     = prod7 >>> 3;
  assign round_up = prod7[PROD_W-1] && (prod7[2:0] != 3'd0);
  assign quot_tz  = ACC_W'(quot) + ACC_W'(round_up);
  assign acc_nxt  = quot_tz + x_ext;
  assign y_full   = x8 - acc_nxt;

  // Output count and end-of-recording mark.
  assign out_cnt_nxt = out_cnt_r + COUNT_W'(1);
  assign last_nxt    = in_stop_request || (out_cnt_nxt >= max_samples_r);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_count_r  <= SKIP_RESET;
      max_samples_r <= MAX_RESET;
      keep_right_r  <= KEEP_RIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SKIP_COUNT:  skip_count_r  <= cfg_data[SKIP_W-1:0];
        CFG_MAX_SAMPLES: max_samples_r <= cfg_data[COUNT_W-1:0];
        CFG_KEEP_RIGHT:  keep_right_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Filter state update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      warm_cnt_r <= '0;
      seeded_r   <= 1'b0;
      out_cnt_r  <= '0;
      finished_r <= 1'b0;
    end else if (active) begin
      if (warming) begin
        warm_cnt_r <= warm_cnt_r + SKIP_W'(1);
      end else begin
        acc_r     <= acc_nxt;
        seeded_r  <= 1'b1;
        out_cnt_r <= out_cnt_nxt;
        if (last_nxt) begin
          finished_r <= 1'b1;
        end
      end
    end
  end

  // Result register: valid is control, the payload loads only with a new beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (produce) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      out_sample_r <= y_full[SAMPLE_WIDTH-1:0];
      out_last_r   <= last_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_filtered_sample = out_sample_r;
  assign out_last_sample     = out_last_r;

  // Once recording ends it stays ended.
  `ASSERT_NXT(a_finished_sticky, finished_r, finished_r, "finished flag dropped")
  // A finished recording has been seeded.
  `ASSERT_IMP(a_finished_seeded, finished_r, seeded_r, "finished without seeding")
  // A pending last beat means recording has ended.
  `ASSERT_IMP(a_last_finishes, out_valid_r && out_last_r, finished_r,
              "last beat pending while recording active")
  // No output is counted before the accumulator is seeded.
  `ASSERT_IMP(a_count_after_seed, !seeded_r, out_cnt_r == '0, "output counted before seed")
  // The accumulator stays within eight times the sample range.
  `ASSERT_IMP(a_acc_bounded, 1'b1, (acc_r <= ACC_MAX) && (acc_r >= ACC_MIN),
              "accumulator out of range")

endmodule

// File: bench/testbench.sv
// Self-checking bench for mic_dc_blocking_filter: warmup drop, seeding, filtering, end of recording.
// Depends on mdcb_pkg and the filter RTL; a built-in predictor holds the expected output samples.
`timescale 1ns / 1ps

module testbench;
  import mdcb_pkg::*;

  localparam int SMP_MAX      = 2 ** (SAMPLE_WIDTH - 1) - 1;
  localparam int SMP_MIN      = -(2 ** (SAMPLE_WIDTH - 1));
  localparam int LONG_HOLD    = 300;
  localparam int LIMIT_CYCLES = 200000;
  localparam int SETTLE       = 8;

  typedef struct {
    logic signed [SAMPLE_WIDTH-1:0] left;
    logic signed [SAMPLE_WIDTH-1:0] right;
    logic                           stop;
  } frame_t;

  typedef struct {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last;
  } out_sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SAMPLE_WIDTH-1:0] in_left_sample = '0;
  logic signed [SAMPLE_WIDTH-1:0] in_right_sample = '0;
  logic in_stop_request = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_WIDTH-1:0] out_filtered_sample;
  logic out_last_sample;

  mic_dc_blocking_filter dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_left_sample      (in_left_sample),
    .in_right_sample     (in_right_sample),
    .in_stop_request     (in_stop_request),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_filtered_sample (out_filtered_sample),
    .out_last_sample     (out_last_sample)
  );

  // Frames waiting to be sent and output samples waiting to arrive.
  frame_t      pending_frames[$];
  out_sample_t expected_samples[$];

  // Bench copy of the registers.
  logic [SKIP_W-1:0]  skip_len   = SKIP_RESET;
  logic [COUNT_W-1:0] max_len    = MAX_RESET;
  logic               pick_right = KEEP_RIGHT_RESET;

  // Bench copy of the filter state.
  int                 acc_q      = 0;
  logic [SKIP_W-1:0]  warm_cnt   = '0;
  logic               is_seeded  = 1'b0;
  logic [COUNT_W-1:0] sample_cnt = '0;
  logic               rec_done   = 1'b0;

  // Pacing controls, set by the stimulus process between phases.
  logic sender_calm   = 1'b0;
  logic receiver_calm = 1'b0;
  logic long_hold_req = 1'b0;

  int mismatch_count = 0;
  int cycle_count    = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Filter update for one accepted frame; pushes the output sample it produces, if any.
  task automatic dc_block_step(input frame_t f);
    int          x;
    int          y;
    out_sample_t r;
    if (rec_done) return;
    x = pick_right ? int'(f.right) : int'(f.left);
    if (!is_seeded) begin
      // Still dropping samples at the start of the recording.
      if (warm_cnt < skip_len) begin
        warm_cnt = warm_cnt + 1'b1;
        return;
      end
      acc_q = x * 8;
      is_seeded = 1'b1;
    end
    // Leaky integrator: SV division truncates toward zero.
    acc_q = (acc_q * 7) / 8 + x;
    y = x * 8 - acc_q;
    sample_cnt = sample_cnt + 1'b1;
    r.sample = SAMPLE_WIDTH'(y);
    r.last = f.stop || (sample_cnt >= max_len);
    if (r.last) rec_done = 1'b1;
    expected_samples.push_back(r);
  endtask

  // Input driver: one beat per frame, with a random gap drawn per frame unless sender_calm is set.
  int gap_left = 0;
  frame_t cur_frame;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) dc_block_step(cur_frame);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_frames.size() > 0) begin
          cur_frame = pending_frames.pop_front();
          in_left_sample <= cur_frame.left;
          in_right_sample <= cur_frame.right;
          in_stop_request <= cur_frame.stop;
          in_valid <= 1'b1;
          gap_left = sender_calm ? 0 : $urandom_range(0, 10);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each beat against the oldest expected sample, stalls at random unless receiver_calm is set.
  int stall_left = 0;
  int hold_left = 0;
  logic long_hold_done = 1'b0;
  out_sample_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Unexpected output beat: sample %0d last %0b",
                     out_filtered_sample, out_last_sample);
        end else begin
          want = expected_samples.pop_front();
          if (out_filtered_sample !== want.sample || out_last_sample !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("Output mismatch: expected sample %0d last %0b, got sample %0d last %0b",
                       want.sample, want.last, out_filtered_sample, out_last_sample);
          end
        end
        stall_left = receiver_calm ? 0 : $urandom_range(0, 10);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (long_hold_req && !long_hold_done) begin
        // Long back-pressure so the filter fills up and stalls its input.
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Register write; the bench copy changes at once since writes happen only while idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(value);
    case (idx)
      CFG_SKIP_COUNT:  skip_len = SKIP_W'(value);
      CFG_MAX_SAMPLES: max_len = COUNT_W'(value);
      CFG_KEEP_RIGHT:  pick_right = value[0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every frame is sent and every output sample has arrived, then lets
  // the pipeline settle since dropped frames leave nothing to wait for.
  task automatic wait_idle();
    @(negedge clk);
    while (pending_frames.size() > 0 || in_valid || expected_samples.size() > 0)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic frame_t make_frame(input int l, input int r, input logic stop);
    frame_t f;
    f.left = SAMPLE_WIDTH'(l);
    f.right = SAMPLE_WIDTH'(r);
    f.stop = stop;
    return f;
  endfunction

  // Mix of full-scale extremes, full-range noise and a signal riding on a DC offset.
  function automatic int rand_sample(input int dc);
    int v;
    case ($urandom_range(0, 9))
      0:       v = SMP_MIN;
      1:       v = SMP_MAX;
      2, 3, 4: v = int'($urandom_range(0, 65535)) + SMP_MIN;
      default: v = dc + int'($urandom_range(0, 2047)) - 1024;
    endcase
    return v;
  endfunction

  initial begin
    int ph;
    int k;
    int dc_l;
    int dc_r;
    int lo;
    int dir_left[10]  = '{SMP_MIN, SMP_MIN, SMP_MAX, SMP_MAX, 0, -1, 1, SMP_MAX, SMP_MIN, 0};
    int dir_right[10] = '{SMP_MAX, SMP_MAX, SMP_MIN, SMP_MIN, 0, -1, 12345, -12345,
                          SMP_MAX, SMP_MIN};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Warmup: long skip and a count limit of one; stop requests here must be ignored.
    write_reg(CFG_SKIP_COUNT, 255);
    write_reg(CFG_MAX_SAMPLES, 1);
    write_reg(CFG_KEEP_RIGHT, 0);
    end_writes();
    @(negedge clk);
    pending_frames.push_back(make_frame(SMP_MIN, SMP_MAX, 1'b1));
    pending_frames.push_back(make_frame(SMP_MAX, SMP_MIN, 1'b0));
    pending_frames.push_back(make_frame(0, -1, 1'b1));
    pending_frames.push_back(make_frame(-1, 0, 1'b0));
    for (k = 0; k < 8; k++)
      pending_frames.push_back(make_frame(rand_sample(0), rand_sample(0), 1'b1));
    wait_idle();

    // Cutting the skip below the dropped count ends warmup; the next frame seeds.
    write_reg(CFG_SKIP_COUNT, 0);
    write_reg(CFG_MAX_SAMPLES, 16777215);
    end_writes();
    @(negedge clk);
    for (k = 0; k < 10; k++)
      pending_frames.push_back(make_frame(dir_left[k], dir_right[k], 1'b0));
    wait_idle();

    // Same extremes on the right channel, with the left one swinging the other way.
    write_reg(CFG_KEEP_RIGHT, 1);
    end_writes();
    @(negedge clk);
    for (k = 0; k < 10; k++)
      pending_frames.push_back(make_frame(dir_right[k], dir_left[k], 1'b0));
    wait_idle();

    // Random phases: new channel, skip and limit each time, different pacing.
    for (ph = 0; ph < 5; ph++) begin
      sender_calm = (ph == 1 || ph == 2);
      receiver_calm = (ph == 2);
      lo = int'(sample_cnt) + 400;
      write_reg(CFG_KEEP_RIGHT, $urandom_range(0, 1));
      write_reg(CFG_SKIP_COUNT, (ph == 0) ? 255 : $urandom_range(0, 255));
      write_reg(CFG_MAX_SAMPLES, (ph == 3) ? 16777215 : $urandom_range(16777215, lo));
      end_writes();
      dc_l = int'($urandom_range(0, 16000)) - 8000;
      dc_r = int'($urandom_range(0, 16000)) - 8000;
      @(negedge clk);
      if (ph == 1) long_hold_req = 1'b1;
      for (k = 0; k < 280; k++)
        pending_frames.push_back(make_frame(rand_sample(dc_l), rand_sample(dc_r), 1'b0));
      wait_idle();
    end

    // Final phase: the recording ends on a stop request or on reaching the count limit,
    // whichever comes first; frames after that give nothing.
    sender_calm = 1'b0;
    receiver_calm = 1'b0;
    lo = int'(sample_cnt);
    write_reg(CFG_KEEP_RIGHT, $urandom_range(0, 1));
    write_reg(CFG_MAX_SAMPLES, lo + $urandom_range(5, 20));
    end_writes();
    @(negedge clk);
    for (k = 0; k < 60; k++)
      pending_frames.push_back(make_frame(rand_sample(dc_l), rand_sample(dc_r),
                                          $urandom_range(0, 19) == 0));

    @(negedge clk);
    while (pending_frames.size() > 0 || in_valid || expected_samples.size() > 0)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);

    if (mismatch_count == 0 && expected_samples.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/mdcb_pkg.sv
rtl/core/mic_dc_blocking_filter.sv
bench/testbench.sv
